// File: hdl/pbts_pkg.sv
// Shared types, codes and defaults of the priority bitmap task scheduler.
package pbts_pkg;

    localparam int NUM_TASKS_DEF  = 16;
    localparam int NUM_LEVELS_DEF = 32;

    localparam int CMD_W     = 3;
    localparam int TASK_W    = 4;
    localparam int LEVEL_W   = 5;
    localparam int COUNT_W   = 32;
    localparam int MASK_W    = 32;
    localparam int SLICE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [SLICE_W-1:0] SLICE_RELOAD_RST = SLICE_W'(10);
    localparam logic [LEVEL_W-1:0] IDLE_LEVEL_RST   = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 3'd0,
        CMD_REMOVE   = 3'd1,
        CMD_REQUEUE  = 3'd2,
        CMD_ROTATE   = 3'd3,
        CMD_SCHEDULE = 3'd4,
        CMD_TICK     = 3'd5,
        CMD_PREEMPT  = 3'd6
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLICE_RELOAD = 2'd0,
        REG_IDLE_LEVEL   = 2'd1
    } reg_idx_t;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

endpackage

// File: hdl/pbts_req_if.sv
// Command channel of the scheduler: one item per command.
interface pbts_req_if;
    import pbts_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [TASK_W-1:0]  task_id;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output cmd, output task_id, output level, input ready);
    modport sink   (input valid, input cmd, input task_id, input level, output ready);
endinterface

// File: hdl/pbts_rsp_if.sv
// Result channel of the scheduler: one item per command.
interface pbts_rsp_if;
    import pbts_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [TASK_W-1:0]  cur_task;
    logic               cur_valid;
    logic               resched_req;
    logic               switched;
    logic [MASK_W-1:0]  ready_mask;
    logic [COUNT_W-1:0] tick_total;
    logic [COUNT_W-1:0] tick_idle;
    logic [COUNT_W-1:0] switch_total;

    modport source (
        output valid, output status, output cur_task, output cur_valid,
        output resched_req, output switched, output ready_mask,
        output tick_total, output tick_idle, output switch_total,
        input ready
    );
    modport sink (
        input valid, input status, input cur_task, input cur_valid,
        input resched_req, input switched, input ready_mask,
        input tick_total, input tick_idle, input switch_total,
        output ready
    );
endinterface

// File: hdl/pbts_cfg_if.sv
// Configuration write channel of the scheduler.
interface pbts_cfg_if;
    import pbts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/priority_bitmap_task_scheduler.sv
// Hardware ready-queue scheduler: per-level task FIFOs, level bitmap, tick and switch counters.
//
// Each command item is captured in an input register, fully evaluated by one pass of
// combinational logic against the scheduler state, and its result lands in the result
// register when that register advances. A result therefore passes through the input register
// and then the result register, where it waits until taken. While the result side
// keeps taking results, one command is accepted every cycle. The result register is the
// only thing that can throttle the rate: while a finished result waits, the input register
// still takes one more command, and further commands wait until the result is taken.
// Task links, queue heads and tails live in flip-flop tables that are only read for queued
// tasks and non-empty levels, so they need no clearing after reset. Configuration writes
// are taken every cycle and must only arrive while no command is in flight.
module priority_bitmap_task_scheduler #(
    parameter int NUM_TASKS  = pbts_pkg::NUM_TASKS_DEF,
    parameter int NUM_LEVELS = pbts_pkg::NUM_LEVELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pbts_req_if.sink   req,
    pbts_rsp_if.source rsp,
    pbts_cfg_if.sink   cfg
);
    import pbts_pkg::*;

    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_LEVELS);

    typedef logic [TW-1:0] tid_t;
    typedef logic [LW-1:0] lvl_t;

    // Input register
    logic               st_vld_reg;
    logic [CMD_W-1:0]   st_cmd_reg;
    logic [TASK_W-1:0]  st_task_reg;
    logic [LEVEL_W-1:0] st_level_reg;

    // Configuration
    logic [SLICE_W-1:0] slice_reload_reg;
    logic [LEVEL_W-1:0] idle_level_reg;

    // Scheduler state
    lvl_t               task_level_reg  [NUM_TASKS];
    lvl_t               task_level_next [NUM_TASKS];
    logic [NUM_TASKS-1:0] task_queued_reg, task_queued_next;
    tid_t               nxt_link_reg  [NUM_TASKS];
    tid_t               nxt_link_next [NUM_TASKS];
    tid_t               prv_link_reg  [NUM_TASKS];
    tid_t               prv_link_next [NUM_TASKS];
    tid_t               head_reg  [NUM_LEVELS];
    tid_t               head_next [NUM_LEVELS];
    tid_t               tail_reg  [NUM_LEVELS];
    tid_t               tail_next [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] level_mask_reg, level_mask_next;
    tid_t               running_task_reg, running_task_next;
    logic               running_valid_reg, running_valid_next;
    logic [SLICE_W-1:0] slice_left_reg  [NUM_TASKS];
    logic [SLICE_W-1:0] slice_left_next [NUM_TASKS];
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] idle_reg, idle_next;
    logic [COUNT_W-1:0] switch_reg, switch_next;

    // Result register
    logic               rsp_vld_reg;
    logic               rsp_status_reg, status_next;
    logic               rsp_resched_reg, resched_next;
    logic               rsp_switched_reg, switched_next;

    // Decode and datapath helpers
    logic               fire, adv;
    logic               args_ok;
    tid_t               t, r, top_task;
    lvl_t               lv, r_lvl, top_lvl, ul_lvl;
    logic               top_found, can_rotate, slice_exp;
    logic [SLICE_W-1:0] slice_dec;
    logic               do_unlink, set_level, do_append;
    tid_t               ul_t, app_t, ul_p, ul_n, app_tl;
    lvl_t               app_lv;
    logic               is_head, is_tail;

    // The result register advances when empty or being taken.
    assign adv       = !rsp_vld_reg || rsp.ready;
    assign fire      = st_vld_reg && adv;
    assign req.ready = !st_vld_reg || adv;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        task_level_next    = task_level_reg;
        task_queued_next   = task_queued_reg;
        nxt_link_next      = nxt_link_reg;
        prv_link_next      = prv_link_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        level_mask_next    = level_mask_reg;
        running_task_next  = running_task_reg;
        running_valid_next = running_valid_reg;
        slice_left_next    = slice_left_reg;
        total_next         = total_reg;
        idle_next          = idle_reg;
        switch_next        = switch_reg;
        status_next        = STATUS_DONE;
        resched_next       = 1'b0;
        switched_next      = 1'b0;

        args_ok = (32'(st_task_reg) < NUM_TASKS) && (32'(st_level_reg) < NUM_LEVELS);
        t       = tid_t'(st_task_reg);
        lv      = lvl_t'(st_level_reg);
        r       = running_task_reg;
        r_lvl   = task_level_reg[r];

        // Highest non-empty level wins.
        top_found = |level_mask_reg;
        top_lvl   = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (level_mask_reg[i])
            begin
                top_lvl = lvl_t'(i);
            end
        end
        top_task = head_reg[top_lvl];

        can_rotate = running_valid_reg && task_queued_reg[r] &&
                     (head_reg[r_lvl] != tail_reg[r_lvl]);
        slice_dec  = slice_left_reg[r] - SLICE_W'(slice_left_reg[r] != '0);
        slice_exp  = (slice_dec == '0);

        do_unlink = 1'b0;
        set_level = 1'b0;
        do_append = 1'b0;
        ul_t      = t;
        app_t     = t;
        app_lv    = lv;

        unique case (cmd_t'(st_cmd_reg))
            CMD_ADD:
            begin
                if (!args_ok || task_queued_reg[t])
                begin
                    status_next = STATUS_IGNORED;
                end
                else
                begin
                    set_level = 1'b1;
                    do_append = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if ((32'(st_task_reg) >= NUM_TASKS) || !task_queued_reg[t])
                begin
                    status_next = STATUS_IGNORED;
                end
                else
                begin
                    do_unlink = 1'b1;
                end
            end
            CMD_REQUEUE:
            begin
                if (!args_ok)
                begin
                    status_next = STATUS_IGNORED;
                end
                else if (!task_queued_reg[t])
                begin
                    // Priority change sticks even though nothing is queued.
                    set_level   = 1'b1;
                    status_next = STATUS_IGNORED;
                end
                else
                begin
                    do_unlink = 1'b1;
                    set_level = 1'b1;
                    do_append = 1'b1;
                end
            end
            CMD_ROTATE:
            begin
                ul_t   = r;
                app_t  = r;
                app_lv = r_lvl;
                if (can_rotate)
                begin
                    do_unlink = 1'b1;
                    do_append = 1'b1;
                end
            end
            CMD_SCHEDULE:
            begin
                if ((top_found != running_valid_reg) || (top_found && (top_task != r)))
                begin
                    switched_next = 1'b1;
                    switch_next   = switch_reg + 1'b1;
                end
                running_valid_next = top_found;
                running_task_next  = top_found ? top_task : '0;
            end
            CMD_TICK:
            begin
                total_next = total_reg + 1'b1;
                ul_t       = r;
                app_t      = r;
                app_lv     = r_lvl;
                if (running_valid_reg)
                begin
                    if (32'(r_lvl) == 32'(idle_level_reg))
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                    slice_left_next[r] = slice_exp ? slice_reload_reg : slice_dec;
                    if (slice_exp)
                    begin
                        resched_next = 1'b1;
                        if (can_rotate)
                        begin
                            do_unlink = 1'b1;
                            do_append = 1'b1;
                        end
                    end
                end
            end
            CMD_PREEMPT:
            begin
                if (top_found && !(running_valid_reg && (top_task == r)) &&
                    (!running_valid_reg || (task_level_reg[top_task] > r_lvl)))
                begin
                    resched_next = 1'b1;
                end
            end
            default:
            begin
                status_next = STATUS_IGNORED;
            end
        endcase

        // Unlink from the task's current level.
        ul_lvl  = task_level_reg[ul_t];
        is_head = (head_reg[ul_lvl] == ul_t);
        is_tail = (tail_reg[ul_lvl] == ul_t);
        ul_p    = prv_link_reg[ul_t];
        ul_n    = nxt_link_reg[ul_t];
        if (do_unlink)
        begin
            if (is_head && is_tail)
            begin
                level_mask_next[ul_lvl] = 1'b0;
            end
            else if (is_head)
            begin
                head_next[ul_lvl] = ul_n;
            end
            else if (is_tail)
            begin
                tail_next[ul_lvl]   = ul_p;
                nxt_link_next[ul_p] = ul_p;
            end
            else
            begin
                nxt_link_next[ul_p] = ul_n;
                prv_link_next[ul_n] = ul_p;
            end
            task_queued_next[ul_t] = 1'b0;
        end

        if (set_level)
        begin
            task_level_next[t] = lv;
        end

        // Append at the tail, seeing the effect of the unlink above.
        app_tl = tail_next[app_lv];
        if (do_append)
        begin
            if (level_mask_next[app_lv])
            begin
                nxt_link_next[app_tl] = app_t;
                prv_link_next[app_t]  = app_tl;
            end
            else
            begin
                head_next[app_lv]    = app_t;
                prv_link_next[app_t] = app_t;
            end
            nxt_link_next[app_t]    = app_t;
            tail_next[app_lv]       = app_t;
            level_mask_next[app_lv] = 1'b1;
            task_queued_next[app_t] = 1'b1;
        end
    end

    // Handshake control and cleared state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg        <= 1'b0;
            rsp_vld_reg       <= 1'b0;
            slice_reload_reg  <= SLICE_RELOAD_RST;
            idle_level_reg    <= IDLE_LEVEL_RST;
            task_queued_reg   <= '0;
            level_mask_reg    <= '0;
            running_task_reg  <= '0;
            running_valid_reg <= 1'b0;
            total_reg         <= '0;
            idle_reg          <= '0;
            switch_reg        <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                task_level_reg[i] <= '0;
                slice_left_reg[i] <= '0;
            end
        end
        else
        begin
            st_vld_reg  <= (req.valid && req.ready) || (st_vld_reg && !adv);
            rsp_vld_reg <= fire || (rsp_vld_reg && !rsp.ready);
            if (cfg.valid)
            begin
                unique case (reg_idx_t'(cfg.index))
                    REG_SLICE_RELOAD: slice_reload_reg <= cfg.data[SLICE_W-1:0];
                    REG_IDLE_LEVEL:   idle_level_reg   <= cfg.data[LEVEL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (fire)
            begin
                task_queued_reg   <= task_queued_next;
                level_mask_reg    <= level_mask_next;
                running_task_reg  <= running_task_next;
                running_valid_reg <= running_valid_next;
                total_reg         <= total_next;
                idle_reg          <= idle_next;
                switch_reg        <= switch_next;
                task_level_reg    <= task_level_next;
                slice_left_reg    <= slice_left_next;
            end
        end
    end

    // Payload registers: command capture, link tables and result fields.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            st_cmd_reg   <= req.cmd;
            st_task_reg  <= req.task_id;
            st_level_reg <= req.level;
        end
        if (fire)
        begin
            nxt_link_reg     <= nxt_link_next;
            prv_link_reg     <= prv_link_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            rsp_status_reg   <= status_next;
            rsp_resched_reg  <= resched_next;
            rsp_switched_reg <= switched_next;
        end
    end

    // The counters and running task are held in state; show them straight from there.
    assign rsp.valid        = rsp_vld_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.resched_req  = rsp_resched_reg;
    assign rsp.switched     = rsp_switched_reg;
    assign rsp.cur_task     = TASK_W'(running_task_reg);
    assign rsp.cur_valid    = running_valid_reg;
    assign rsp.ready_mask   = MASK_W'(level_mask_reg);
    assign rsp.tick_total   = total_reg;
    assign rsp.tick_idle    = idle_reg;
    assign rsp.switch_total = switch_reg;

    a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.cur_valid |-> rsp.cur_task == '0)
        else $error("running task number nonzero with no running task");

    a_mask_needs_queued: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(task_queued_reg) == 0 |-> level_mask_reg == '0)
        else $error("level marked non-empty with no queued task");

    a_switch_counted: assert property (@(posedge clk) disable iff (!rst_n)
        fire && switched_next |=> switch_reg == $past(switch_reg) + 1'b1)
        else $error("task switch not counted");

    a_tick_counted: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (st_cmd_reg == CMD_TICK) |=> total_reg == $past(total_reg) + 1'b1)
        else $error("tick not counted");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> st_vld_reg && rsp.valid && !rsp.ready)
        else $error("command held off without a stalled result");

endmodule
